// ===== rtl/median_then_mean_sample_filter_unit_defines.svh =====
// Assertion macros shared by the filter RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef MEDIAN_THEN_MEAN_SAMPLE_FILTER_UNIT_DEFINES_SVH
`define MEDIAN_THEN_MEAN_SAMPLE_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MTMSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MTMSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTMSF_ASSERT_IMP(lbl, ante, cons, msg)
`define MTMSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/mtmsf_pkg.sv =====
// Shared types and constants for the median-then-mean sample filter.
// No dependencies.
package mtmsf_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int JOINT_W    = 3;
    localparam int ANGLE_W    = 15;
    localparam int SAMPLE_MAX = 4095;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [JOINT_W-1:0]  t_joint;
    typedef logic [ANGLE_W-1:0]  t_angle;

    localparam t_angle ANGLE_MAX = 15'h7FFF;

    // window update for one joint
    typedef struct packed {
        logic    en;
        t_joint  joint;
        t_sample sample;
        t_sample median;
    } t_push;

endpackage

// ===== rtl/mtmsf_median.sv =====
// Rank-based median select over one window of samples.
// Depends on mtmsf_pkg.
module mtmsf_median #(
    parameter int TAPS = 5
) (
    input  mtmsf_pkg::t_sample i_win [TAPS],
    output mtmsf_pkg::t_sample o_median
);

    localparam int RW = $clog2(TAPS + 1);
    localparam logic [RW-1:0] MID = RW'(TAPS / 2);

    logic [TAPS-1:0] below [TAPS];
    logic [RW-1:0]   rank  [TAPS];

    // Ties broken by position so the ranks form a permutation.
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS; j++) begin
                below[i][j] = (j != i) &&
                              ((i_win[j] < i_win[i]) || ((i_win[j] == i_win[i]) && (j < i)));
            end
            rank[i] = RW'($countones(below[i]));
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < TAPS; i++) begin
            if (rank[i] == MID) begin
                o_median = o_median | i_win[i];
            end
        end
    end

endmodule

// ===== rtl/mtmsf_store.sv =====
// Per-joint median windows, mean windows and running window sums.
// Depends on mtmsf_pkg.
module mtmsf_store #(
    parameter int JOINTS      = 6,
    parameter int MEDIAN_TAPS = 5,
    parameter int AVG_TAPS    = 8,
    parameter int SUM_W       = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtmsf_pkg::t_joint  i_rd_joint,
    output mtmsf_pkg::t_sample o_med_win [MEDIAN_TAPS],
    output mtmsf_pkg::t_sample o_avg_oldest,
    output logic [SUM_W-1:0]   o_sum,
    input  mtmsf_pkg::t_push   i_push,
    input  logic [SUM_W-1:0]   i_sum
);

    mtmsf_pkg::t_sample r_med [JOINTS][MEDIAN_TAPS];
    mtmsf_pkg::t_sample r_avg [JOINTS][AVG_TAPS];
    logic [SUM_W-1:0]   r_sum [JOINTS];

    // one-hot joint select
    always_comb begin
        for (int k = 0; k < MEDIAN_TAPS; k++) begin
            o_med_win[k] = '0;
        end
        o_avg_oldest = '0;
        o_sum        = '0;
        for (int j = 0; j < JOINTS; j++) begin
            if (int'(i_rd_joint) == j) begin
                for (int k = 0; k < MEDIAN_TAPS; k++) begin
                    o_med_win[k] = o_med_win[k] | r_med[j][k];
                end
                o_avg_oldest = o_avg_oldest | r_avg[j][0];
                o_sum        = o_sum | r_sum[j];
            end
        end
    end

    // oldest entry sits at index 0; new values shift in at the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JOINTS; j++) begin
                for (int k = 0; k < MEDIAN_TAPS; k++) begin
                    r_med[j][k] <= '0;
                end
                for (int k = 0; k < AVG_TAPS; k++) begin
                    r_avg[j][k] <= '0;
                end
                r_sum[j] <= '0;
            end
        end else if (i_push.en) begin
            for (int j = 0; j < JOINTS; j++) begin
                if (int'(i_push.joint) == j) begin
                    for (int k = 0; k < MEDIAN_TAPS - 1; k++) begin
                        r_med[j][k] <= r_med[j][k+1];
                    end
                    r_med[j][MEDIAN_TAPS-1] <= i_push.sample;
                    for (int k = 0; k < AVG_TAPS - 1; k++) begin
                        r_avg[j][k] <= r_avg[j][k+1];
                    end
                    r_avg[j][AVG_TAPS-1] <= i_push.median;
                    r_sum[j] <= i_sum;
                end
            end
        end
    end

endmodule

// ===== rtl/median_then_mean_sample_filter_unit.sv =====
// Per-joint median-then-mean filter: each transaction carries a joint index and a 12-bit ADC
// sample; one result comes back per transaction, in order, passing from the input register to the
// result register when the output side is not stalled. Throughput is one transaction per clock
// while the output is not stalled: the rank-compare median of the updated window and the
// running-sum update (old sum minus oldest median plus new median) complete combinationally
// between the input and result registers, so back-to-back samples of the same joint need no
// forwarding. All window state lives in flip-flops cleared by reset; no clearing pass. A joint
// index at or above JOINTS leaves the state untouched and returns a sum of zero; sums above 32767 clamp.
// Depends on mtmsf_pkg, mtmsf_store, mtmsf_median and the assertion macro header.
`include "median_then_mean_sample_filter_unit_defines.svh"

module median_then_mean_sample_filter_unit #(
    parameter int JOINTS      = 6,
    parameter int MEDIAN_TAPS = 5,
    parameter int AVG_TAPS    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mtmsf_pkg::t_joint  i_joint_index,
    input  mtmsf_pkg::t_sample i_adc_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output mtmsf_pkg::t_joint  o_joint_echo,
    output mtmsf_pkg::t_angle  o_angle_sum
);

    localparam int SUM_W = $clog2(AVG_TAPS * mtmsf_pkg::SAMPLE_MAX + 1);
    localparam int CMP_W = (SUM_W > mtmsf_pkg::ANGLE_W) ? SUM_W : mtmsf_pkg::ANGLE_W;

    logic               r_in_valid;
    mtmsf_pkg::t_joint  r_in_joint;
    mtmsf_pkg::t_sample r_in_sample;
    logic               r_out_valid;
    mtmsf_pkg::t_joint  r_out_joint;
    mtmsf_pkg::t_angle  r_out_angle;

    logic               out_adv;
    logic               in_range;
    mtmsf_pkg::t_sample old_win [MEDIAN_TAPS];
    mtmsf_pkg::t_sample new_win [MEDIAN_TAPS];
    mtmsf_pkg::t_sample median;
    mtmsf_pkg::t_sample avg_oldest;
    logic [SUM_W-1:0]   old_sum;
    logic [SUM_W-1:0]   new_sum;
    logic [CMP_W-1:0]   sum_ext;
    mtmsf_pkg::t_angle  n_out_angle;
    mtmsf_pkg::t_push   push;

    assign out_adv  = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || out_adv;
    assign in_range = int'(r_in_joint) < JOINTS;

    mtmsf_store #(
        .JOINTS     (JOINTS),
        .MEDIAN_TAPS(MEDIAN_TAPS),
        .AVG_TAPS   (AVG_TAPS),
        .SUM_W      (SUM_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_joint  (r_in_joint),
        .o_med_win   (old_win),
        .o_avg_oldest(avg_oldest),
        .o_sum       (old_sum),
        .i_push      (push),
        .i_sum       (new_sum)
    );

    always_comb begin
        for (int k = 0; k < MEDIAN_TAPS - 1; k++) begin
            new_win[k] = old_win[k+1];
        end
        new_win[MEDIAN_TAPS-1] = r_in_sample;
    end

    mtmsf_median #(
        .TAPS(MEDIAN_TAPS)
    ) u_median (
        .i_win   (new_win),
        .o_median(median)
    );

    // old_sum always covers avg_oldest, so the subtract cannot wrap
    assign new_sum = (old_sum - SUM_W'(avg_oldest)) + SUM_W'(median);
    assign sum_ext = CMP_W'(new_sum);

    always_comb begin
        if (!in_range) begin
            n_out_angle = '0;
        end else if (sum_ext > CMP_W'(mtmsf_pkg::ANGLE_MAX)) begin
            n_out_angle = mtmsf_pkg::ANGLE_MAX;
        end else begin
            n_out_angle = sum_ext[mtmsf_pkg::ANGLE_W-1:0];
        end
    end

    always_comb begin
        push.en     = r_in_valid && out_adv && in_range;
        push.joint  = r_in_joint;
        push.sample = r_in_sample;
        push.median = median;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_joint  <= i_joint_index;
            r_in_sample <= i_adc_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_out_joint <= r_in_joint;
            r_out_angle <= n_out_angle;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_joint_echo = r_out_joint;
    assign o_angle_sum  = r_out_angle;

    `MTMSF_ASSERT_IMP(a_bad_joint_zero, r_out_valid && (int'(r_out_joint) >= JOINTS), r_out_angle == '0, "out-of-range joint gave nonzero sum")
    `MTMSF_ASSERT_IMP(a_stall_only_full, !o_ready, r_in_valid && r_out_valid, "input stalled with a free stage")
    `MTMSF_ASSERT_NXT(a_advance_lands, r_in_valid && out_adv, r_out_valid, "advanced transaction lost")

endmodule
